// ===== sv/pspd_pkg.sv =====
// Shared widths, constants and handshake types of the PWM sensor decoder.
package pspd_pkg;

    localparam int TimeW     = 32;
    localparam int PpmW      = 14;
    localparam int OffsetW   = 8;
    localparam int NumW      = TimeW + 1;
    localparam int DenW      = TimeW + 3;
    localparam int DivisorW  = TimeW + 2;
    localparam int DividendW = PpmW + TimeW;
    localparam int DivSteps  = DividendW;
    localparam int StepCntW  = $clog2(DivSteps);
    localparam int CfgIdxW   = 1;
    localparam int CfgDataW  = PpmW;

    localparam logic [CfgIdxW-1:0] CfgFullScale = 1'd0;
    localparam logic [CfgIdxW-1:0] CfgOffset    = 1'd1;

    localparam logic [PpmW-1:0]    FullScaleReset = 14'd5000;
    localparam logic [OffsetW-1:0] OffsetReset    = 8'd2;

    typedef struct packed {
        logic                 start;
        logic [DividendW-1:0] dividend;
        logic [DivisorW-1:0]  divisor;
        logic [PpmW-1:0]      limit;
    } div_req_t;

    typedef struct packed {
        logic            done;
        logic [PpmW-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== sv/pspd_if.sv =====
// Valid/ready channels for pin samples and concentration readings.
interface pspd_in_if;
    import pspd_pkg::*;

    logic              valid;
    logic              ready;
    logic              pin_level;
    logic [TimeW-1:0]  sample_time_ms;

    modport source (output valid, output pin_level, output sample_time_ms, input ready);
    modport sink   (input valid, input pin_level, input sample_time_ms, output ready);
endinterface

interface pspd_out_if;
    import pspd_pkg::*;

    logic             valid;
    logic             ready;
    logic [PpmW-1:0]  concentration_ppm;
    logic             reading_valid;

    modport source (output valid, output concentration_ppm, output reading_valid, input ready);
    modport sink   (input valid, input concentration_ppm, input reading_valid, output ready);
endinterface

// ===== sv/pspd_div.sv =====
// Restoring bit-serial divider with quotient clamped to a limit.
module pspd_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  pspd_pkg::div_req_t req,
    output pspd_pkg::div_rsp_t rsp
);
    import pspd_pkg::*;

    logic                 busy_reg,  busy_next;
    logic                 done_reg,  done_next;
    logic [StepCntW-1:0]  cnt_reg,   cnt_next;
    logic [DividendW-1:0] dvd_reg,   dvd_next;
    logic [DivisorW-1:0]  dsr_reg,   dsr_next;
    logic [DivisorW-1:0]  rem_reg,   rem_next;
    logic [PpmW-1:0]      quo_reg,   quo_next;
    logic                 ovf_reg,   ovf_next;
    logic [PpmW-1:0]      lim_reg,   lim_next;

    logic [DivisorW:0]    shifted;
    logic [DivisorW:0]    diff;
    logic                 take;

    assign shifted = {rem_reg, dvd_reg[DividendW-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign take    = shifted >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        lim_next  = lim_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
            quo_next  = '0;
            ovf_next  = 1'b0;
            lim_next  = req.limit;
        end
        else if (busy_reg)
        begin
            rem_next = take ? diff[DivisorW-1:0] : shifted[DivisorW-1:0];
            dvd_next = {dvd_reg[DividendW-2:0], 1'b0};
            quo_next = {quo_reg[PpmW-2:0], take};
            ovf_next = ovf_reg | quo_reg[PpmW-1];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == StepCntW'(DivSteps - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
        lim_reg <= lim_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = (ovf_reg || (quo_reg > lim_reg)) ? lim_reg : quo_reg;

endmodule

// ===== sv/pwm_sensor_ppm_decoder.sv =====
// Top level: PWM phase tracking, reading sequencer and output register.
// Each sample is one transfer on sample_in. A sample that is not a rising edge (level high
// after a stored low) updates the phase timestamps and yields no reading.
// A rising edge yields one reading on reading_out: the transfer edge captures the
// durations, S_PREP forms the numerator and denominator, S_MUL the 14x32 product, the
// divider is loaded and runs its bit-serial steps, S_DIV takes the quotient and S_OUT loads
// the output register. A rising edge with a non-positive denominator or numerator skips the
// divider and goes from S_MUL to S_OUT.
// sample_in is not ready while a reading is being computed; it is ready again while the
// finished reading waits in the output register. The concentration is
// full_scale*(high-offset)/(high+low-2*offset) in ms, truncated and clamped to
// 0..full_scale; reading_valid is low, with a zero concentration, when the denominator
// is not positive. cfg writes set full scale (index 0) and offset (index 1).
module pwm_sensor_ppm_decoder
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pspd_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [pspd_pkg::CfgDataW-1:0]   cfg_data,
    pspd_in_if.sink                         sample_in,
    pspd_out_if.source                      reading_out
);
    import pspd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [PpmW-1:0]      full_scale_reg;
    logic [OffsetW-1:0]   offset_reg;
    logic                 prev_level_reg;
    logic [TimeW-1:0]     high_start_reg, high_last_reg, low_start_reg, low_last_reg;
    logic [TimeW-1:0]     high_dur_reg, low_dur_reg;
    logic [NumW-1:0]      num_reg;
    logic [DenW-1:0]      den_reg;
    logic [DividendW-1:0] prod_reg;
    logic                 start_reg;
    logic [PpmW-1:0]      res_ppm_reg;
    logic                 res_valid_reg;
    logic                 out_valid_reg;
    logic [PpmW-1:0]      out_ppm_reg;
    logic                 out_rv_reg;

    logic                 accept;
    logic                 rising;
    logic                 den_pos;
    logic                 num_pos;
    logic                 out_free;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    assign accept   = sample_in.valid && sample_in.ready;
    assign rising   = sample_in.pin_level && !prev_level_reg;
    assign den_pos  = !den_reg[DenW-1] && (den_reg != '0);
    assign num_pos  = !num_reg[NumW-1] && (num_reg != '0);
    assign out_free = !out_valid_reg || reading_out.ready;

    assign sample_in.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && rising)
                    state_next = S_PREP;
            end
            S_PREP:
                state_next = S_MUL;
            S_MUL:
                state_next = (den_pos && num_pos) ? S_DIV : S_OUT;
            S_DIV:
            begin
                if (div_rsp.done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            full_scale_reg <= FullScaleReset;
            offset_reg     <= OffsetReset;
            prev_level_reg <= 1'b0;
            high_start_reg <= '0;
            high_last_reg  <= '0;
            low_start_reg  <= '0;
            low_last_reg   <= '0;
            start_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= (state_reg == S_MUL) && den_pos && num_pos;
            if (cfg_we)
            begin
                case (cfg_index)
                    CfgFullScale: full_scale_reg <= cfg_data;
                    CfgOffset:    offset_reg     <= cfg_data[OffsetW-1:0];
                    default:      ;
                endcase
            end
            if (accept)
            begin
                if (sample_in.pin_level)
                begin
                    if (!prev_level_reg)
                    begin
                        high_start_reg <= sample_in.sample_time_ms;
                        prev_level_reg <= 1'b1;
                    end
                    else
                        high_last_reg <= sample_in.sample_time_ms;
                end
                else
                begin
                    if (prev_level_reg)
                    begin
                        low_start_reg  <= sample_in.sample_time_ms;
                        prev_level_reg <= 1'b0;
                    end
                    else
                        low_last_reg <= sample_in.sample_time_ms;
                end
            end
            if ((state_reg == S_OUT) && out_free)
                out_valid_reg <= 1'b1;
            else if (reading_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && rising)
        begin
            high_dur_reg <= high_last_reg - high_start_reg;
            low_dur_reg  <= low_last_reg - low_start_reg;
        end
        if (state_reg == S_PREP)
        begin
            num_reg <= {1'b0, high_dur_reg} - {{(NumW-OffsetW){1'b0}}, offset_reg};
            den_reg <= {3'b000, high_dur_reg} + {3'b000, low_dur_reg}
                       - {{(DenW-OffsetW-1){1'b0}}, offset_reg, 1'b0};
        end
        if (state_reg == S_MUL)
        begin
            prod_reg      <= DividendW'(full_scale_reg) * DividendW'(num_reg[TimeW-1:0]);
            res_ppm_reg   <= '0;
            res_valid_reg <= den_pos;
        end
        if ((state_reg == S_DIV) && div_rsp.done)
            res_ppm_reg <= div_rsp.quotient;
        if ((state_reg == S_OUT) && out_free)
        begin
            out_ppm_reg <= res_ppm_reg;
            out_rv_reg  <= res_valid_reg;
        end
    end

    assign div_req.start    = start_reg;
    assign div_req.dividend = prod_reg;
    assign div_req.divisor  = den_reg[DivisorW-1:0];
    assign div_req.limit    = full_scale_reg;

    pspd_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign reading_out.valid             = out_valid_reg;
    assign reading_out.concentration_ppm = out_ppm_reg;
    assign reading_out.reading_valid     = out_rv_reg;

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide phase");

    a_rise_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && rising) |=> (state_reg == S_PREP))
        else $error("rising edge did not start a reading");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_rv_reg) |-> (out_ppm_reg == '0))
        else $error("invalid reading carries a nonzero concentration");

    a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_ppm_reg <= full_scale_reg))
        else $error("reading exceeds full scale");

    a_start_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> $past(state_reg == S_MUL))
        else $error("divider started without a product");

endmodule

// ===== tb/ppm_reading_check.sv =====
// Checker for the PWM decoder: tracks pin phases, predicts readings and compares transfers.
module ppm_reading_check
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pspd_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [pspd_pkg::CfgDataW-1:0] cfg_data,
    pspd_in_if                            sample_in,
    pspd_out_if                           reading_out,
    output int                            pending,
    output int                            errors
);
    import pspd_pkg::*;

    typedef struct packed {
        logic [PpmW-1:0] ppm;
        logic            ok;
    } reading_t;

    logic [PpmW-1:0]    full_scale;
    logic [OffsetW-1:0] offset;
    logic               was_high;
    logic [TimeW-1:0]   high_start;
    logic [TimeW-1:0]   high_last;
    logic [TimeW-1:0]   low_start;
    logic [TimeW-1:0]   low_last;
    reading_t           expected_readings[$];

    task automatic report_mismatch(input string msg);
        if (errors < 40)
            $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic reading_t predict_reading();
        logic [TimeW-1:0] high_ms;
        logic [TimeW-1:0] low_ms;
        longint           h;
        longint           l;
        longint           o;
        longint           f;
        longint           num;
        longint           den;
        longint           quo;
        reading_t         r;
        high_ms = high_last - high_start;
        low_ms  = low_last - low_start;
        h       = high_ms;
        l       = low_ms;
        o       = offset;
        f       = full_scale;
        num     = h - o;
        den     = h + l - 2 * o;
        r.ppm   = '0;
        r.ok    = 1'b0;
        if (den > 0)
        begin
            r.ok = 1'b1;
            if (num > 0)
            begin
                quo = (f * num) / den;
                if (quo > f)
                    quo = f;
                r.ppm = quo[PpmW-1:0];
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            full_scale = FullScaleReset;
            offset     = OffsetReset;
            was_high   = 1'b0;
            high_start = '0;
            high_last  = '0;
            low_start  = '0;
            low_last   = '0;
            expected_readings.delete();
            errors     = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CfgFullScale)
                    full_scale = cfg_data;
                else if (cfg_index == CfgOffset)
                    offset = cfg_data[OffsetW-1:0];
            end
            if (reading_out.valid && reading_out.ready)
            begin
                if (expected_readings.size() == 0)
                    report_mismatch($sformatf("reading %0d/%0b with none expected",
                                              reading_out.concentration_ppm,
                                              reading_out.reading_valid));
                else
                begin
                    want = expected_readings.pop_front();
                    if (reading_out.concentration_ppm !== want.ppm)
                        report_mismatch($sformatf("concentration_ppm %0d, expected %0d",
                                                  reading_out.concentration_ppm, want.ppm));
                    if (reading_out.reading_valid !== want.ok)
                        report_mismatch($sformatf("reading_valid %0b, expected %0b",
                                                  reading_out.reading_valid, want.ok));
                end
            end
            if (sample_in.valid && sample_in.ready)
            begin
                if (sample_in.pin_level)
                begin
                    if (!was_high)
                    begin
                        expected_readings.push_back(predict_reading());
                        high_start = sample_in.sample_time_ms;
                        was_high   = 1'b1;
                    end
                    else
                        high_last = sample_in.sample_time_ms;
                end
                else
                begin
                    if (was_high)
                    begin
                        low_start = sample_in.sample_time_ms;
                        was_high  = 1'b0;
                    end
                    else
                        low_last = sample_in.sample_time_ms;
                end
            end
        end
        pending = expected_readings.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: clock, reset, sample stimulus, reading drain and verdict for the PWM decoder.
module tb_top;
    import pspd_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;
    int                  pending;
    int                  errors;
    logic                steady;
    logic                squeeze_req;
    logic [TimeW-1:0]    now;

    pspd_in_if  sample_ch ();
    pspd_out_if reading_ch ();

    pwm_sensor_ppm_decoder DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample_in   (sample_ch),
        .reading_out (reading_ch)
    );

    ppm_reading_check reading_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample_in   (sample_ch),
        .reading_out (reading_ch),
        .pending     (pending),
        .errors      (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #8000000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_sample(input logic level, input logic [TimeW-1:0] t);
        int gap;
        if (!steady && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 18);
            sample_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid          = 1'b1;
        sample_ch.pin_level      = level;
        sample_ch.sample_time_ms = t;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_quiet();
        sample_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic set_scale(input logic [PpmW-1:0] fs, input logic [OffsetW-1:0] off);
        cfg_we    = 1'b1;
        cfg_index = CfgFullScale;
        cfg_data  = fs;
        @(negedge clk);
        cfg_index = CfgOffset;
        cfg_data  = {{(CfgDataW-OffsetW){1'b0}}, off};
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    function automatic logic [TimeW-1:0] next_gap(input int span);
        case (span)
            0:       return $urandom_range(0, 8);
            1:       return $urandom_range(0, 80);
            2:       return $urandom_range(0, 700);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_traffic(input int count);
        int sent;
        int span;
        int reps;
        sent = 0;
        now  = $urandom;
        while (sent < count)
        begin
            if ($urandom_range(0, 19) == 0)
                now = 32'hFFFF_FFFF - $urandom_range(0, 400);
            if ($urandom_range(0, 9) == 0)
            begin
                send_sample(1'($urandom_range(0, 1)), $urandom);
                sent++;
            end
            else
            begin
                span = $urandom_range(0, 3);
                reps = $urandom_range(1, 4);
                repeat (reps)
                begin
                    send_sample(1'b1, now);
                    now += next_gap(span);
                    sent++;
                end
                reps = $urandom_range(1, 4);
                repeat (reps)
                begin
                    send_sample(1'b0, now);
                    now += next_gap(span);
                    sent++;
                end
            end
        end
    endtask

    // drain readings: random stalls, one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (squeeze_req)
            begin
                squeeze_req      = 1'b0;
                reading_ch.ready = 1'b0;
                repeat (600) @(negedge clk);
            end
            else if (!steady && $urandom_range(0, 7) == 0)
            begin
                reading_ch.ready = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            reading_ch.ready = 1'b1;
        end
    end

    initial
    begin
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_index                = CfgFullScale;
        cfg_data                 = '0;
        sample_ch.valid          = 1'b0;
        sample_ch.pin_level      = 1'b0;
        sample_ch.sample_time_ms = '0;
        reading_ch.ready         = 1'b0;
        steady                   = 1'b0;
        squeeze_req              = 1'b0;
        now                      = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // rising edge straight after reset: zero durations, no valid reading
        send_sample(1'b1, 32'd100);
        send_sample(1'b1, 32'd110);
        send_sample(1'b1, 32'd130);
        send_sample(1'b0, 32'd140);
        send_sample(1'b0, 32'd150);
        send_sample(1'b0, 32'd190);
        send_sample(1'b1, 32'd200);
        // high time within the offset: zero concentration, still valid
        send_sample(1'b1, 32'd201);
        send_sample(1'b0, 32'd202);
        send_sample(1'b0, 32'd400);
        send_sample(1'b1, 32'd401);
        // low time zero: quotient above full scale
        send_sample(1'b1, 32'd500);
        send_sample(1'b0, 32'd501);
        send_sample(1'b0, 32'd501);
        send_sample(1'b1, 32'd502);
        // high phase never updated after its start: wrapped duration
        send_sample(1'b0, 32'd503);
        send_sample(1'b0, 32'd510);
        send_sample(1'b1, 32'd520);
        // timestamps across the wrap
        send_sample(1'b0, 32'hFFFF_FFF0);
        send_sample(1'b0, 32'hFFFF_FFFF);
        send_sample(1'b1, 32'hFFFF_FFFC);
        send_sample(1'b1, 32'h0000_0010);
        send_sample(1'b0, 32'h0000_0020);
        send_sample(1'b0, 32'h0000_0040);
        send_sample(1'b1, 32'h0000_0041);
        wait_quiet();

        set_scale(14'd1000, 8'd0);
        squeeze_req = 1'b1;
        run_traffic(290);
        wait_quiet();

        set_scale(14'd10000, 8'd255);
        run_traffic(290);
        wait_quiet();

        set_scale(14'h3FFF, 8'd0);
        run_traffic(290);
        wait_quiet();

        set_scale(14'd0, OffsetW'($urandom_range(0, 255)));
        run_traffic(290);
        wait_quiet();

        set_scale(PpmW'($urandom_range(1000, 10000)), OffsetW'($urandom_range(0, 255)));
        run_traffic(290);
        wait_quiet();

        steady = 1'b1;
        set_scale(FullScaleReset, OffsetReset);
        run_traffic(290);
        wait_quiet();

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
